// ===== rtl/core/tofq_pkg.sv =====
package tofq_pkg;

    localparam int TOF_W      = 32;
    localparam int KC_W       = 40;
    localparam int TOF_FRAC   = 8;
    localparam int DIVIDEND_W = KC_W + TOF_FRAC;
    localparam int K_W        = DIVIDEND_W;
    localparam int DIV_STAGES = DIVIDEND_W;
    localparam int SIN_W      = 17;
    localparam int MUL_W      = 64;

    // latencies counted from the divider output register
    localparam int MUL_LAT = 4;
    localparam int QS_LAT  = 3;
    localparam int S2_DLY  = 2 * MUL_LAT;
    localparam int W_TAP   = 3 * MUL_LAT;
    localparam int F_DLY   = MUL_LAT;
    localparam int OUT_T   = 5 * MUL_LAT;
    localparam int Q_DLY   = OUT_T - QS_LAT;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_LORENTZ = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_MIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_MAX   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MAX   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_MIN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_MAX   = 3'd6;

    localparam logic signed [31:0] BOX_MIN_RESET = -32'sd3276800;
    localparam logic signed [31:0] BOX_MAX_RESET = 32'sd3276800;

    typedef struct packed {
        logic [TOF_W-1:0]  flight_time;
        logic [31:0]       event_weight;
        logic [31:0]       event_error_sq;
        logic signed [31:0] qdir_x;
        logic signed [31:0] qdir_y;
        logic signed [31:0] qdir_z;
        logic [KC_W-1:0]   wavenumber_const;
        logic [SIN_W-1:0]  lorentz_sin_sq;
    } tofq_event_t;

    typedef struct packed {
        logic signed [31:0] q_x;
        logic signed [31:0] q_y;
        logic signed [31:0] q_z;
        logic [31:0]        weight_out;
        logic [31:0]        error_sq_out;
    } tofq_result_t;

    // event fields that ride along with the divider
    typedef struct packed {
        logic [31:0]        event_weight;
        logic [31:0]        event_error_sq;
        logic signed [31:0] qdir_x;
        logic signed [31:0] qdir_y;
        logic signed [31:0] qdir_z;
        logic [SIN_W-1:0]   lorentz_sin_sq;
    } tofq_side_t;

endpackage

// ===== rtl/core/tof_event_to_q_vector.sv =====
// channel | handshake               | payload                     | dir | beat
// --------+-------------------------+-----------------------------+-----+-----------------
// event   | event_valid/event_ready | event_data (tofq_event_t)   | in  | one event
// q       | q_valid/q_ready         | q_data (tofq_result_t)      | out | one Q point
// cfg     | cfg_valid/cfg_ready     | cfg_index, cfg_data         | in  | one reg write
//
// One event per cycle while the output is not stalled. A kept event passes through the
// 48 divider stages for k (the first loads at the edge that takes its beat), 20 for
// the Lorentz chain (five 4-stage multipliers deep) and one output register to q_data.
// Dropped events leave bubbles. Reset clears the valid bits and sets the config registers
// to their reset values. When the output register is full and not taken, every stage
// holds and event_ready drops in the same cycle. cfg is always ready.
module tof_event_to_q_vector
    import tofq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 event_valid,
    output logic                 event_ready,
    input  tofq_event_t          event_data,
    output logic                 q_valid,
    input  logic                 q_ready,
    output tofq_result_t         q_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    logic               lorentz_reg;
    logic signed [31:0] box_lo_reg [3];
    logic signed [31:0] box_hi_reg [3];

    logic         adv;
    logic         q_valid_reg;
    tofq_result_t q_data_reg;
    tofq_result_t q_data_next;

    logic       div_valid;
    logic [K_W-1:0] k;
    tofq_side_t side;
    tofq_side_t side_in;

    logic [31:0] q_lane [3];
    logic [2:0]  inbox_lane;

    logic [MUL_W-1:0] k2, k4, f, wf, ef, eff;

    logic [OUT_T-1:0]  valid_line_reg;
    logic [31:0]       w_line_reg  [OUT_T];
    logic [31:0]       e_line_reg  [OUT_T];
    logic [SIN_W-1:0]  s2_line_reg [S2_DLY];
    logic [MUL_W-1:0]  f_line_reg  [F_DLY];
    logic [31:0]       wf_line_reg [F_DLY];
    logic [Q_DLY-1:0]  inbox_line_reg;
    logic [31:0]       qx_line_reg [Q_DLY];
    logic [31:0]       qy_line_reg [Q_DLY];
    logic [31:0]       qz_line_reg [Q_DLY];

    assign adv         = !q_valid_reg || q_ready;
    assign event_ready = adv;
    assign cfg_ready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lorentz_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                box_lo_reg[i] <= BOX_MIN_RESET;
                box_hi_reg[i] <= BOX_MAX_RESET;
            end
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LORENTZ: lorentz_reg   <= cfg_data[0];
                CFG_X_MIN:   box_lo_reg[0] <= $signed(cfg_data);
                CFG_X_MAX:   box_hi_reg[0] <= $signed(cfg_data);
                CFG_Y_MIN:   box_lo_reg[1] <= $signed(cfg_data);
                CFG_Y_MAX:   box_hi_reg[1] <= $signed(cfg_data);
                CFG_Z_MIN:   box_lo_reg[2] <= $signed(cfg_data);
                CFG_Z_MAX:   box_hi_reg[2] <= $signed(cfg_data);
                default:     ;
            endcase
        end
    end

    assign side_in.event_weight   = event_data.event_weight;
    assign side_in.event_error_sq = event_data.event_error_sq;
    assign side_in.qdir_x         = event_data.qdir_x;
    assign side_in.qdir_y         = event_data.qdir_y;
    assign side_in.qdir_z         = event_data.qdir_z;
    assign side_in.lorentz_sin_sq = event_data.lorentz_sin_sq;

    // zero flight time never gets a valid bit
    tofq_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (event_valid && (event_data.flight_time != '0)),
        .dividend  ({event_data.wavenumber_const, {TOF_FRAC{1'b0}}}),
        .divisor   (event_data.flight_time),
        .in_side   (side_in),
        .out_valid (div_valid),
        .quotient  (k),
        .out_side  (side)
    );

    tofq_qscale u_qs_x (
        .clk (clk), .adv (adv), .dir (side.qdir_x), .k (k),
        .lo (box_lo_reg[0]), .hi (box_hi_reg[0]), .q (q_lane[0]), .inbox (inbox_lane[0])
    );

    tofq_qscale u_qs_y (
        .clk (clk), .adv (adv), .dir (side.qdir_y), .k (k),
        .lo (box_lo_reg[1]), .hi (box_hi_reg[1]), .q (q_lane[1]), .inbox (inbox_lane[1])
    );

    tofq_qscale u_qs_z (
        .clk (clk), .adv (adv), .dir (side.qdir_z), .k (k),
        .lo (box_lo_reg[2]), .hi (box_hi_reg[2]), .q (q_lane[2]), .inbox (inbox_lane[2])
    );

    tofq_mulsat u_k2 (
        .clk (clk), .adv (adv), .cap32 (1'b0),
        .a (MUL_W'(k)), .b (MUL_W'(k)), .p (k2)
    );

    tofq_mulsat u_k4 (
        .clk (clk), .adv (adv), .cap32 (1'b0), .a (k2), .b (k2), .p (k4)
    );

    tofq_mulsat u_f (
        .clk (clk), .adv (adv), .cap32 (1'b0),
        .a (MUL_W'(s2_line_reg[S2_DLY-1])), .b (k4), .p (f)
    );

    tofq_mulsat u_wf (
        .clk (clk), .adv (adv), .cap32 (1'b1),
        .a (MUL_W'(w_line_reg[W_TAP-1])), .b (f), .p (wf)
    );

    tofq_mulsat u_ef (
        .clk (clk), .adv (adv), .cap32 (1'b0),
        .a (MUL_W'(e_line_reg[W_TAP-1])), .b (f), .p (ef)
    );

    tofq_mulsat u_eff (
        .clk (clk), .adv (adv), .cap32 (1'b1),
        .a (ef), .b (f_line_reg[F_DLY-1]), .p (eff)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_line_reg <= '0;
        end
        else if (adv)
        begin
            valid_line_reg <= {valid_line_reg[OUT_T-2:0], div_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_line_reg[0]   <= side.event_weight;
            e_line_reg[0]   <= side.event_error_sq;
            s2_line_reg[0]  <= side.lorentz_sin_sq;
            f_line_reg[0]   <= f;
            wf_line_reg[0]  <= wf[31:0];
            inbox_line_reg  <= {inbox_line_reg[Q_DLY-2:0], &inbox_lane};
            qx_line_reg[0]  <= q_lane[0];
            qy_line_reg[0]  <= q_lane[1];
            qz_line_reg[0]  <= q_lane[2];
            for (int i = 1; i < OUT_T; i++)
            begin
                w_line_reg[i] <= w_line_reg[i-1];
                e_line_reg[i] <= e_line_reg[i-1];
            end
            for (int i = 1; i < S2_DLY; i++)
            begin
                s2_line_reg[i] <= s2_line_reg[i-1];
            end
            for (int i = 1; i < F_DLY; i++)
            begin
                f_line_reg[i]  <= f_line_reg[i-1];
                wf_line_reg[i] <= wf_line_reg[i-1];
            end
            for (int i = 1; i < Q_DLY; i++)
            begin
                qx_line_reg[i] <= qx_line_reg[i-1];
                qy_line_reg[i] <= qy_line_reg[i-1];
                qz_line_reg[i] <= qz_line_reg[i-1];
            end
        end
    end

    always_comb
    begin
        q_data_next.q_x = $signed(qx_line_reg[Q_DLY-1]);
        q_data_next.q_y = $signed(qy_line_reg[Q_DLY-1]);
        q_data_next.q_z = $signed(qz_line_reg[Q_DLY-1]);
        if (lorentz_reg)
        begin
            q_data_next.weight_out   = wf_line_reg[F_DLY-1];
            q_data_next.error_sq_out = eff[31:0];
        end
        else
        begin
            q_data_next.weight_out   = w_line_reg[OUT_T-1];
            q_data_next.error_sq_out = e_line_reg[OUT_T-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            q_valid_reg <= valid_line_reg[OUT_T-1] && inbox_line_reg[Q_DLY-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_data_reg <= q_data_next;
        end
    end

    assign q_valid = q_valid_reg;
    assign q_data  = q_data_reg;

endmodule

// ===== rtl/core/tofq_div.sv =====
module tofq_div
    import tofq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [TOF_W-1:0]      divisor,
    input  tofq_side_t            in_side,
    output logic                  out_valid,
    output logic [DIVIDEND_W-1:0] quotient,
    output tofq_side_t            out_side
);

    // one quotient bit per stage; nq holds the remaining dividend bits on top
    // and the quotient bits shifting in at the bottom
    logic [DIV_STAGES-1:0] valid_reg;
    logic [TOF_W-1:0]      rem_reg  [DIV_STAGES-1];
    logic [TOF_W-1:0]      den_reg  [DIV_STAGES-1];
    logic [DIVIDEND_W-1:0] nq_reg   [DIV_STAGES];
    tofq_side_t            side_reg [DIV_STAGES];

    logic [TOF_W-1:0]      rem_src  [DIV_STAGES];
    logic [TOF_W-1:0]      den_src  [DIV_STAGES];
    logic [DIVIDEND_W-1:0] nq_src   [DIV_STAGES];
    logic [TOF_W-1:0]      rem_next [DIV_STAGES-1];
    logic [DIVIDEND_W-1:0] nq_next  [DIV_STAGES];

    always_comb
    begin
        rem_src[0] = '0;
        den_src[0] = divisor;
        nq_src[0]  = dividend;
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            rem_src[s] = rem_reg[s-1];
            den_src[s] = den_reg[s-1];
            nq_src[s]  = nq_reg[s-1];
        end
    end

    always_comb
    begin
        logic [TOF_W:0] trial;
        logic [TOF_W:0] diff;
        logic           ge;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            trial      = {rem_src[s], nq_src[s][DIVIDEND_W-1]};
            diff       = trial - {1'b0, den_src[s]};
            ge         = (trial >= {1'b0, den_src[s]});
            nq_next[s] = {nq_src[s][DIVIDEND_W-2:0], ge};
            if (s < DIV_STAGES - 1)
            begin
                rem_next[s] = ge ? diff[TOF_W-1:0] : trial[TOF_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[DIV_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= in_side;
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                nq_reg[s] <= nq_next[s];
            end
            for (int s = 0; s < DIV_STAGES - 1; s++)
            begin
                rem_reg[s] <= rem_next[s];
                den_reg[s] <= den_src[s];
            end
            for (int s = 1; s < DIV_STAGES; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign quotient  = nq_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule

// ===== rtl/core/tofq_mulsat.sv =====
module tofq_mulsat
    import tofq_pkg::*;
(
    input  logic             clk,
    input  logic             adv,
    input  logic             cap32,
    input  logic [MUL_W-1:0] a,
    input  logic [MUL_W-1:0] b,
    output logic [MUL_W-1:0] p
);

    // (a*b) >> 16, saturating; four 32x32 partial products, then
    // middle sum, full 128-bit sum, saturation
    logic [MUL_W-1:0]   p00_reg, p01_reg, p10_reg, p11_reg;
    logic [MUL_W:0]     mid_reg;
    logic [MUL_W-1:0]   lo_reg, hi_reg;
    logic [2*MUL_W-1:0] full_reg;
    logic [MUL_W-1:0]   p_reg;

    logic [2*MUL_W-1:0] full_next;
    logic [MUL_W-1:0]   r;
    logic [MUL_W-1:0]   cap;
    logic [MUL_W-1:0]   p_next;

    assign full_next = {hi_reg, lo_reg} + {31'b0, mid_reg, 32'b0};
    assign r         = full_reg[MUL_W+15:16];
    assign cap       = cap32 ? {32'b0, 32'hFFFF_FFFF} : '1;

    always_comb
    begin
        if (|full_reg[2*MUL_W-1:MUL_W+16])
        begin
            p_next = cap;
        end
        else if (cap32 && (|r[MUL_W-1:32]))
        begin
            p_next = cap;
        end
        else
        begin
            p_next = r;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p00_reg  <= 64'(a[31:0])  * 64'(b[31:0]);
            p01_reg  <= 64'(a[31:0])  * 64'(b[63:32]);
            p10_reg  <= 64'(a[63:32]) * 64'(b[31:0]);
            p11_reg  <= 64'(a[63:32]) * 64'(b[63:32]);
            mid_reg  <= {1'b0, p01_reg} + {1'b0, p10_reg};
            lo_reg   <= p00_reg;
            hi_reg   <= p11_reg;
            full_reg <= full_next;
            p_reg    <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// ===== rtl/core/tofq_qscale.sv =====
module tofq_qscale
    import tofq_pkg::*;
(
    input  logic               clk,
    input  logic               adv,
    input  logic signed [31:0] dir,
    input  logic [K_W-1:0]     k,
    input  logic signed [31:0] lo,
    input  logic signed [31:0] hi,
    output logic [31:0]        q,
    output logic               inbox
);

    logic [31:0] mag;
    logic [63:0] hi_prod_reg;
    logic [47:0] lo_prod_reg;
    logic        neg_reg;

    logic [63:0]        m;
    logic [32:0]        mc;
    logic signed [33:0] qw;
    logic signed [33:0] q_reg;
    logic signed [33:0] lo_ext, hi_ext;
    logic [31:0]        q_out_reg;
    logic               inbox_reg;

    assign mag = dir[31] ? (~unsigned'(dir) + 32'd1) : unsigned'(dir);

    // magnitude truncates toward zero, clamp at 2^32 before the sign goes back
    assign m  = hi_prod_reg + {32'b0, lo_prod_reg[47:16]};
    assign mc = (m > 64'h1_0000_0000) ? 33'h1_0000_0000 : m[32:0];
    assign qw = neg_reg ? -$signed({1'b0, mc}) : $signed({1'b0, mc});

    assign lo_ext = $signed({{2{lo[31]}}, lo});
    assign hi_ext = $signed({{2{hi[31]}}, hi});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hi_prod_reg <= 64'(mag) * 64'(k[K_W-1:16]);
            lo_prod_reg <= 48'(mag) * 48'(k[15:0]);
            neg_reg     <= dir[31];
            q_reg       <= qw;
            q_out_reg   <= q_reg[31:0];
            inbox_reg   <= (q_reg >= lo_ext) && (q_reg < hi_ext);
        end
    end

    assign q     = q_out_reg;
    assign inbox = inbox_reg;

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tofq_pkg::*;

    localparam int    LIMIT    = 400000;
    localparam int    DRAIN    = 80;     // margin for the pipeline to empty, dropped events leave no beat
    localparam int    N_DIRECT = 13;
    localparam int    ONE      = 65536;  // 1.0 in Q16.16
    localparam longint Q_LO    = -64'sd2147483648;
    localparam longint Q_HI    = 64'sd2147483647;
    localparam logic [KC_W-1:0]      KC_MAX     = '1;
    localparam logic [63:0]          SAT64      = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0]          SAT32      = 64'h0000_0000_FFFF_FFFF;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic [CFG_IDX_W-1:0] BOUND_REG [6] =
        '{CFG_X_MIN, CFG_X_MAX, CFG_Y_MIN, CFG_Y_MAX, CFG_Z_MIN, CFG_Z_MAX};

    class q_point_tracker;
        bit           lorentz_on;
        longint       box_lo [3];
        longint       box_hi [3];
        tofq_result_t q_points_due [$];
        int           n_events, n_checked, n_dropped, n_sat, n_errors;

        function new();
            int i;
            lorentz_on = 1'b0;
            for (i = 0; i < 3; i++) begin
                box_lo[i] = BOX_MIN_RESET;
                box_hi[i] = BOX_MAX_RESET;
            end
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
            logic signed [31:0] sval;
            sval = val;
            case (idx)
                CFG_LORENTZ: lorentz_on = val[0];
                CFG_X_MIN:   box_lo[0] = sval;
                CFG_X_MAX:   box_hi[0] = sval;
                CFG_Y_MIN:   box_lo[1] = sval;
                CFG_Y_MAX:   box_hi[1] = sval;
                CFG_Z_MIN:   box_lo[2] = sval;
                CFG_Z_MAX:   box_hi[2] = sval;
                default:     ;
            endcase
        endfunction

        // (a*b) >> 16 on the full product, clipped at cap
        function logic [63:0] q16_mul(logic [63:0] a, logic [63:0] b, logic [63:0] cap);
            logic [127:0] prod;
            prod = ({64'b0, a} * {64'b0, b}) >> 16;
            return (prod > {64'b0, cap}) ? cap : prod[63:0];
        endfunction

        // direction times k, truncated toward zero, magnitude clipped at 2^32
        function longint scaled_axis(logic signed [31:0] dir, logic [K_W-1:0] k);
            logic [31:0] mag;
            logic [95:0] prod;
            longint      m;
            mag  = dir[31] ? (~dir + 32'd1) : dir;
            prod = ({64'b0, mag} * {48'b0, k}) >> 16;
            if (prod > 96'h1_0000_0000)
                prod = 96'h1_0000_0000;
            m = longint'(prod[63:0]);
            return dir[31] ? -m : m;
        endfunction

        function bit convert_event(tofq_event_t ev, output tofq_result_t r);
            logic [K_W-1:0]     k;
            logic signed [31:0] dir [3];
            longint             q [3];
            logic [63:0]        k2, k4, f, w, e;
            int                 i;
            r = '0;
            if (ev.flight_time == '0)
                return 1'b0;
            k = {ev.wavenumber_const, 8'b0} / {16'b0, ev.flight_time};
            dir[0] = ev.qdir_x;
            dir[1] = ev.qdir_y;
            dir[2] = ev.qdir_z;
            for (i = 0; i < 3; i++) begin
                q[i] = scaled_axis(dir[i], k);
                if (q[i] < box_lo[i] || q[i] >= box_hi[i])
                    return 1'b0;
            end
            w = {32'b0, ev.event_weight};
            e = {32'b0, ev.event_error_sq};
            if (lorentz_on) begin
                k2 = q16_mul({16'b0, k}, {16'b0, k}, SAT64);
                k4 = q16_mul(k2, k2, SAT64);
                f  = q16_mul({47'b0, ev.lorentz_sin_sq}, k4, SAT64);
                w  = q16_mul(w, f, SAT32);
                e  = q16_mul(q16_mul(e, f, SAT64), f, SAT32);
                if (w == SAT32)
                    n_sat++;
            end
            r.q_x          = q[0][31:0];
            r.q_y          = q[1][31:0];
            r.q_z          = q[2][31:0];
            r.weight_out   = w[31:0];
            r.error_sq_out = e[31:0];
            return 1'b1;
        endfunction

        function void note_event(tofq_event_t ev);
            tofq_result_t r;
            n_events++;
            if (convert_event(ev, r))
                q_points_due = {q_points_due, r};
            else
                n_dropped++;
        endfunction

        function void flag(string what, logic [31:0] want, logic [31:0] got);
            n_errors++;
            if (n_errors <= 10)
                $display("tb: mismatch on %s: expected %h, got %h", what, want, got);
        endfunction

        function void check_result(tofq_result_t got);
            tofq_result_t want;
            if (q_points_due.size() == 0) begin
                flag("Q beat with no event pending", '0, got.q_x);
                return;
            end
            want = q_points_due.pop_front();
            n_checked++;
            if (got.q_x !== want.q_x)                   flag("q_x", want.q_x, got.q_x);
            if (got.q_y !== want.q_y)                   flag("q_y", want.q_y, got.q_y);
            if (got.q_z !== want.q_z)                   flag("q_z", want.q_z, got.q_z);
            if (got.weight_out !== want.weight_out)     flag("weight_out", want.weight_out,
                                                             got.weight_out);
            if (got.error_sq_out !== want.error_sq_out) flag("error_sq_out", want.error_sq_out,
                                                             got.error_sq_out);
        endfunction

        function int pending();
            return q_points_due.size();
        endfunction
    endclass

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 event_valid = 1'b0;
    logic                 event_ready;
    tofq_event_t          event_data  = '0;
    logic                 q_valid;
    logic                 q_ready     = 1'b0;
    tofq_result_t         q_data;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [31:0]          cfg_data    = '0;

    q_point_tracker board;
    bit             steady      = 1'b0;
    int             hold_cycles = 0;
    int             cycles      = 0;
    int             n_backpressure = 0;

    always #2 clk = ~clk;

    tof_event_to_q_vector uut (
        .clk, .rst_n,
        .event_valid, .event_ready, .event_data,
        .q_valid, .q_ready, .q_data,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    always @(posedge clk)
        if (event_valid && !event_ready)
            n_backpressure++;

    function automatic logic [63:0] rand_bits(int n);
        logic [63:0] r;
        r = {$urandom, $urandom};
        return (n <= 0) ? 64'd0 : r >> (64 - n);
    endfunction

    function automatic tofq_event_t pack_event(logic [31:0] tof, logic [31:0] w,
                                               logic [31:0] e, logic [31:0] dx,
                                               logic [31:0] dy, logic [31:0] dz,
                                               logic [KC_W-1:0] kc, logic [SIN_W-1:0] s2);
        tofq_event_t ev;
        ev.flight_time      = tof;
        ev.event_weight     = w;
        ev.event_error_sq   = e;
        ev.qdir_x           = dx;
        ev.qdir_y           = dy;
        ev.qdir_z           = dz;
        ev.wavenumber_const = kc;
        ev.lorentz_sin_sq   = s2;
        return ev;
    endfunction

    // k = 1.0 is tof 256 with constant 65536; edges of the +-50 box sit at +-3276800
    function automatic tofq_event_t directed_event(int n);
        case (n)
            0:  return pack_event(0, 32'h1234_5678, 32'h9ABC, ONE, ONE, ONE, 40'd65536,
                                  17'd32768);
            1:  return pack_event(256, ONE, 2 * ONE, ONE, 2 * ONE, -3 * ONE, 40'd65536,
                                  17'd32768);
            2:  return pack_event('1, '1, '1, 0, 0, 0, KC_MAX, 17'd65536);
            3:  return pack_event(256, 12345, 0, 32'h8000_0000, 32'h7FFF_FFFF,
                                  32'h8000_0000, 40'd0, 17'd131071);
            4:  return pack_event(1, 1, 1, 0, 0, 0, KC_MAX, 17'd1);     // huge k, q = 0
            5:  return pack_event(1, 1, 1, 1, 0, 0, KC_MAX, 17'd1);     // q past the box, out
            6:  return pack_event(256, 0, '1, -3276800, 3276799, -3276800, 40'd65536, 17'd65536);
            7:  return pack_event(256, ONE, ONE, 3276800, 0, 0, 40'd65536, 17'd65536);
            8:  return pack_event(256, ONE, ONE, 0, -3276801, 0, 40'd65536, 17'd65536);
            9:  return pack_event(256, ONE, ONE, 0, 0, 3276800, 40'd65536, 17'd65536);
            10: return pack_event(512, 32'h8000_0000, ONE, -1, 1, -65537, 40'd65536, 17'd131071);
            11: return pack_event(128, 32'h00FF_FFFF, 32'h0001_FFFF, 10 * ONE, -24 * ONE, 3,
                                  40'd65536, 17'd16384);
            default: return pack_event(0, '1, '1, 32'h8000_0000, 32'h7FFF_FFFF, 0, KC_MAX,
                                       17'd131071);
        endcase
    endfunction

    function automatic tofq_event_t noise_event();
        tofq_event_t ev;
        ev.flight_time      = $urandom;
        ev.event_weight     = $urandom;
        ev.event_error_sq   = $urandom;
        ev.qdir_x           = $urandom;
        ev.qdir_y           = $urandom;
        ev.qdir_z           = $urandom;
        ev.wavenumber_const = {8'($urandom), 32'($urandom)};
        ev.lorentz_sin_sq   = 17'($urandom);
        return ev;
    endfunction

    // aims each Q coordinate into the current box so most events survive
    function automatic tofq_event_t shaped_event(bit zero_tof);
        tofq_event_t    ev;
        logic [63:0]    k_aim, r;
        logic [95:0]    kc_full;
        logic [K_W-1:0] k_real;
        longint         target, span, qd;
        logic [31:0]    dir [3];
        int             i;
        ev.flight_time = 32'(rand_bits($urandom_range(1, 32)));
        if (ev.flight_time == '0)
            ev.flight_time = 32'd1;
        k_aim = rand_bits(($urandom_range(0, 9) == 0) ? $urandom_range(25, 48)
                                                       : $urandom_range(8, 24));
        kc_full = ({48'b0, k_aim[47:0]} * {64'b0, ev.flight_time}) >> 8;
        ev.wavenumber_const = (kc_full > {56'b0, KC_MAX}) ? KC_MAX : kc_full[KC_W-1:0];
        k_real = {ev.wavenumber_const, 8'b0} / {16'b0, ev.flight_time};
        for (i = 0; i < 3; i++) begin
            if (board.box_hi[i] > board.box_lo[i]) begin
                span   = board.box_hi[i] - board.box_lo[i];
                r      = {$urandom, $urandom};
                target = board.box_lo[i] + longint'(r % span);
            end else
                target = longint'(int'($urandom));
            if (k_real == '0)
                qd = longint'(int'($urandom));
            else begin
                qd = (target * 65536) / longint'({16'b0, k_real});
                if ($urandom_range(0, 3) == 0)
                    qd = qd + longint'($urandom_range(0, 2)) - 1;
            end
            if (qd > Q_HI) qd = Q_HI;
            if (qd < Q_LO) qd = Q_LO;
            dir[i] = qd[31:0];
        end
        ev.qdir_x         = dir[0];
        ev.qdir_y         = dir[1];
        ev.qdir_z         = dir[2];
        ev.event_weight   = 32'(rand_bits($urandom_range(0, 32)));
        ev.event_error_sq = 32'(rand_bits($urandom_range(0, 32)));
        ev.lorentz_sin_sq = ($urandom_range(0, 7) == 0) ? 17'($urandom_range(65537, 131071))
                                                        : 17'($urandom_range(0, 65536));
        if (zero_tof)
            ev.flight_time = '0;
        return ev;
    endfunction

    function automatic void random_box(output logic [31:0] lim [6]);
        longint mid, half, lo, hi;
        int     i;
        for (i = 0; i < 3; i++) begin
            mid = longint'(rand_bits($urandom_range(0, 26)));
            if ($urandom_range(0, 1) == 1)
                mid = -mid;
            half = longint'(rand_bits($urandom_range(4, 30))) + 1;
            lo = mid - half;
            hi = mid + half;
            if (lo < Q_LO) lo = Q_LO;
            if (hi > Q_HI) hi = Q_HI;
            lim[2 * i]     = lo[31:0];
            lim[2 * i + 1] = hi[31:0];
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.note_config(idx, val);
    endtask

    task automatic apply_settings(input bit en, input logic [31:0] lim [6], input bit poke_unused);
        logic [31:0] word;
        int          i;
        word    = $urandom;
        word[0] = en;
        write_reg(CFG_LORENTZ, word);
        for (i = 0; i < 6; i++)
            write_reg(BOUND_REG[i], lim[i]);
        if (poke_unused)
            write_reg(CFG_UNUSED, $urandom);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_event(input tofq_event_t ev);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            event_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        event_valid <= 1'b1;
        event_data  <= ev;
        @(posedge clk);
        while (!event_ready)
            @(posedge clk);
        board.note_event(ev);
    endtask

    task automatic run_directed();
        int n;
        for (n = 0; n < N_DIRECT; n++)
            send_event(directed_event(n));
    endtask

    task automatic run_random(input int count);
        int n, roll;
        for (n = 0; n < count; n++) begin
            roll = $urandom_range(0, 19);
            if (roll < 2)
                send_event(noise_event());
            else
                send_event(shaped_event(roll == 2));
        end
    endtask

    task automatic settle();
        event_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    initial begin : watchdog
        while (cycles < LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: done, errors");
        $finish;
    end

    initial begin : q_sink
        int pause;
        @(posedge rst_n);
        forever begin
            if (hold_cycles > 0) begin
                q_ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            pause = steady ? 0 : $urandom_range(0, 10);
            if (pause > 0) begin
                q_ready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            q_ready <= 1'b1;
            @(posedge clk);
            while (!q_valid)
                @(posedge clk);
            board.check_result(q_data);
        end
    end

    initial begin : stimulus
        logic [31:0] lim [6];
        board = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset values: Lorentz off, +-50 box
        run_directed();
        settle();

        lim = '{BOX_MIN_RESET, BOX_MAX_RESET, BOX_MIN_RESET, BOX_MAX_RESET,
                BOX_MIN_RESET, BOX_MAX_RESET};
        apply_settings(1'b1, lim, 1'b0);
        run_directed();
        run_random(150);
        settle();

        lim = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h7FFF_FFFF};
        apply_settings(1'b0, lim, 1'b0);
        run_random(150);
        settle();

        // long output stall with back to back input so the pipe backs up
        apply_settings(1'b1, lim, 1'b0);
        steady      = 1'b1;
        hold_cycles = 400;
        run_random(150);
        settle();
        steady = 1'b0;

        random_box(lim);
        apply_settings(1'b1, lim, 1'b0);
        run_random(150);
        settle();

        // empty x range, inverted y range: everything drops
        lim = '{32'd0, 32'd0, 32'd100, -32'd100, BOX_MIN_RESET, BOX_MAX_RESET};
        apply_settings(1'b0, lim, 1'b1);
        run_random(40);
        settle();

        random_box(lim);
        apply_settings(1'b0, lim, 1'b0);
        run_random(150);
        settle();

        lim = '{-ONE, ONE, -ONE, ONE, -ONE, ONE};
        apply_settings(1'b1, lim, 1'b0);
        steady = 1'b1;
        run_random(150);
        settle();
        steady = 1'b0;

        random_box(lim);
        lim[0] = 32'h8000_0000;
        apply_settings(1'b0, lim, 1'b1);
        run_random(150);
        settle();

        $display("tb: %0d events sent, %0d Q points checked, %0d dropped, %0d mismatches",
                 board.n_events, board.n_checked, board.n_dropped, board.n_errors);
        $display("tb: %0d saturated corrected weights, %0d cycles of input backpressure",
                 board.n_sat, n_backpressure);
        if (board.n_errors == 0 && board.pending() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule
